>>> src/mcis_pkg.sv
// ----------------------------------------------------------------------------
// mcis_pkg: shared types and constants for the modal cab impulse sample core
// Mode tables, sequencer states, divider request and fixed-point constants.
// ----------------------------------------------------------------------------
package mcis_pkg;

  // Divider and multiplier widths
  localparam int DIV_DW      = 52;
  localparam int DIV_SW      = 34;
  localparam int MUL_AW      = 37;
  localparam int MUL_BW      = 20;
  localparam int MUL_PW      = MUL_AW + MUL_BW;
  localparam int ACC_W       = 22;
  localparam int TABLE_SLOTS = 9;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAB_TYPE     = 3'd0;
  localparam logic [2:0] CFG_POSITION     = 3'd1;
  localparam logic [2:0] CFG_PHASE_OFFSET = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_DELAY = 3'd3;
  localparam logic [2:0] CFG_LENGTH       = 3'd4;
  localparam logic [2:0] CFG_SAMPLE_RATE  = 3'd5;

  // Sample rate clamp
  localparam logic [17:0] FS_MIN = 18'd8000;
  localparam logic [17:0] FS_MAX = 18'd192000;

  // 1e6 * log2(e) in Q16, scaled for microsecond tau
  localparam logic [MUL_AW-1:0] DECAY_K = 37'd94548000000;

  // Rounded-up reciprocals; exact over the clamped rate and length ranges
  localparam logic [MUL_BW-1:0] RCP_1000 = 20'd268436;  // 2^28 / 1000
  localparam logic [MUL_BW-1:0] RCP_100  = 20'd167773;  // 2^24 / 100
  localparam logic [MUL_BW-1:0] RCP_10   = 20'd26215;   // 2^18 / 10

  // Mode table entry; ew is the precomputed edge weight of the mode frequency
  typedef struct packed {
    logic [12:0] freq;
    logic [14:0] amp;
    logic [15:0] tau;
    logic [16:0] ew;
  } mode_entry_t;

  localparam mode_entry_t MODE_TABLE [4][TABLE_SLOTS] = '{
    '{ '{13'd100, 15'd18022, 16'd30000, 17'd0},
       '{13'd180, 15'd11469, 16'd25000, 17'd0},
       '{13'd400, 15'd8192,  16'd20000, 17'd3276},
       '{13'd800, 15'd7209,  16'd16000, 17'd16384},
       '{13'd1200, 15'd6554, 16'd14000, 17'd29491},
       '{13'd2500, 15'd18022, 16'd12000, 17'd65536},
       '{13'd3200, 15'd16384, 16'd10000, 17'd65536},
       '{13'd4000, 15'd11469, 16'd8000,  17'd65536},
       '{13'd4800, 15'd7209,  16'd6000,  17'd65536} },
    '{ '{13'd90,  15'd16384, 16'd45000, 17'd0},
       '{13'd160, 15'd13107, 16'd40000, 17'd0},
       '{13'd350, 15'd9830,  16'd35000, 17'd1638},
       '{13'd600, 15'd14746, 16'd30000, 17'd9830},
       '{13'd850, 15'd11469, 16'd25000, 17'd18022},
       '{13'd1800, 15'd9830, 16'd18000, 17'd49152},
       '{13'd2800, 15'd9175, 16'd14000, 17'd65536},
       '{13'd3500, 15'd4915, 16'd10000, 17'd65536},
       '{13'd0,    15'd0,    16'd1,     17'd0} },
    '{ '{13'd110, 15'd9830,  16'd18000, 17'd0},
       '{13'd220, 15'd7209,  16'd16000, 17'd0},
       '{13'd500, 15'd6554,  16'd14000, 17'd6553},
       '{13'd900, 15'd5898,  16'd12000, 17'd19660},
       '{13'd1500, 15'd8192, 16'd10000, 17'd39321},
       '{13'd2800, 15'd13107, 16'd10000, 17'd65536},
       '{13'd3800, 15'd12452, 16'd9000,  17'd65536},
       '{13'd5200, 15'd9830,  16'd7000,  17'd65536},
       '{13'd0,    15'd0,     16'd1,     17'd0} },
    '{ '{13'd120, 15'd13107, 16'd22000, 17'd0},
       '{13'd260, 15'd16384, 16'd28000, 17'd0},
       '{13'd450, 15'd11469, 16'd20000, 17'd4915},
       '{13'd700, 15'd8192,  16'd16000, 17'd13107},
       '{13'd1400, 15'd7209, 16'd12000, 17'd36044},
       '{13'd2200, 15'd9830, 16'd10000, 17'd62259},
       '{13'd3000, 15'd6554, 16'd8000,  17'd65536},
       '{13'd0,    15'd0,    16'd1,     17'd0},
       '{13'd0,    15'd0,    16'd1,     17'd0} }
  };

  localparam logic [3:0] MODE_COUNT [4] = '{4'd9, 4'd8, 4'd8, 4'd7};

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE, ST_CHECK, ST_KD,
    ST_ALEN, ST_ALEN_W, ST_FLEN, ST_FLEN_W, ST_FS100, ST_FS100_W,
    ST_M_FK, ST_M_PH, ST_M_PH_W,
    ST_S1, ST_S2, ST_S3, ST_S4, ST_S5,
    ST_W2, ST_W3, ST_W4,
    ST_D_DIV, ST_D_W, ST_D2, ST_D3, ST_D4, ST_D5,
    ST_A_CHK, ST_A_W, ST_A2, ST_A3,
    ST_F_CHK, ST_F_W, ST_F2,
    ST_OUT
  } state_t;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [5:0]        steps;
    logic [DIV_DW-1:0] dvd;
    logic [DIV_SW-1:0] dvs;
  } div_req_t;

endpackage

>>> src/mcis_div.sv
// ----------------------------------------------------------------------------
// mcis_div: shared restoring divider
// One quotient bit per cycle; the dividend arrives left-aligned with the
// number of significant bits in steps. done pulses with the quotient.
// ----------------------------------------------------------------------------
module mcis_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcis_pkg::div_req_t            req,
  output logic                          done,
  output logic [mcis_pkg::DIV_DW-1:0]   quo
);
  import mcis_pkg::*;

  logic [DIV_DW-1:0] q_r, q_nxt;
  logic [DIV_SW-1:0] rem_r, rem_nxt;
  logic [DIV_SW-1:0] dvs_r, dvs_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_SW:0]   rem_sh;
  logic [DIV_SW:0]   rem_sub;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    rem_sh   = {rem_r, q_r[DIV_DW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt   = req.dvd;
      rem_nxt = '0;
      dvs_nxt = req.dvs;
      cnt_nxt = req.steps;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[DIV_SW-1:0];
        q_nxt   = {q_r[DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_SW-1:0];
        q_nxt   = {q_r[DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Advance datapath
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> src/modal_cab_impulse_sample_core.sv
// ----------------------------------------------------------------------------
// modal_cab_impulse_sample_core: modal cabinet impulse response sample
// Sums damped sine modes from a constant table, adds an attack transient
// and applies a tail fade, one requested sample at a time.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-------------------
//  request | start, busy, in_sample_index                 | start & !busy
//  result  | out_strobe, out_sample_value, out_index_valid| strobe, one cycle
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | valid & ready
//
// An index outside the length or before the delay is answered straight from
// the check state. Otherwise a request runs setup, then each mode (up to
// nine) in turn, using the one-bit-per-cycle divider to form each mode's
// phase and decay exponent, then the attack and the fade where they apply.
// busy stays high for the whole request. rst_n is synchronous.
// cfg_ready is always high; results cannot be held off.
// ----------------------------------------------------------------------------
module modal_cab_impulse_sample_core #(
  parameter int MAX_SAMPLES = 16384,
  parameter int MAX_MODES   = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [13:0]        in_sample_index,
  output logic               out_strobe,
  output logic signed [19:0] out_sample_value,
  output logic               out_index_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import mcis_pkg::*;

  localparam logic [16:0] MAX_S = 17'(MAX_SAMPLES);
  localparam logic [4:0]  MAXM  = 5'(MAX_MODES);

  // Configuration registers
  logic [1:0]  cab_type_r;
  logic [15:0] position_r;
  logic [15:0] phase_offset_r;
  logic [7:0]  sample_delay_r;
  logic [14:0] length_r;
  logic [17:0] sample_rate_r;

  state_t state_r, state_nxt;

  logic [13:0]       n_r, n_nxt;
  logic [13:0]       k_r, k_nxt;
  logic [50:0]       kd_r, kd_nxt;
  logic [14:0]       alen_r, alen_nxt;
  logic [14:0]       flen_r, flen_nxt;
  logic [3:0]        m_r, m_nxt;
  logic [15:0]       ph_r, ph_nxt;
  logic [14:0]       z_r, z_nxt;
  logic [14:0]       z2_r, z2_nxt;
  logic [15:0]       s_r, s_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       tmag_r, tmag_nxt;
  logic [15:0]       u_r, u_nxt;
  logic [3:0]        i_r, i_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [MUL_PW-1:0] mul_r;
  logic              strobe_r, strobe_nxt;
  logic [19:0]       sample_r, sample_nxt;
  logic              ivalid_r, ivalid_nxt;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_DW-1:0] quo;

  logic [14:0] len;
  logic [17:0] fs;
  logic [14:0] len_d;
  logic        idx_ok, pre_delay, mode_last, decay_big, atk_on, fade_on;
  logic [4:0]  mode_cnt;
  mode_entry_t md;
  logic [16:0] pos_c, adiff, fav;
  logic signed [17:0] diff;
  logic [ACC_W-1:0] acc_mag;
  logic [15:0] term;
  logic [14:0] fi;
  logic signed [ACC_W-1:0] term_s;

  // Resolve effective length, rate and per-mode constants
  always_comb begin
    len       = (17'(length_r) > MAX_S) ? MAX_S[14:0] : length_r;
    fs        = (sample_rate_r < FS_MIN) ? FS_MIN :
                (sample_rate_r > FS_MAX) ? FS_MAX : sample_rate_r;
    len_d     = len - 15'(sample_delay_r);
    idx_ok    = {1'b0, n_r} < len;
    pre_delay = n_r < 14'(sample_delay_r);
    mode_cnt  = (5'(MODE_COUNT[cab_type_r]) < MAXM) ? 5'(MODE_COUNT[cab_type_r]) : MAXM;
    mode_last = ({1'b0, m_r} + 5'd1) >= mode_cnt;
    md        = MODE_TABLE[cab_type_r][m_r];
    decay_big = |quo[DIV_DW-1:20];
    atk_on    = {1'b0, k_r} < alen_r;
    fade_on   = (flen_r != 15'd0) && ({1'b0, n_r} >= (len - flen_r));
    fi        = {1'b0, n_r} - (len - flen_r);
    pos_c     = 17'd65536 - {1'b0, position_r};
    diff      = $signed({1'b0, md.ew}) - $signed({1'b0, pos_c});
    adiff     = diff[17] ? 17'(-diff) : diff[16:0];
    fav       = 17'd65536 - adiff;
    acc_mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    term      = mul_r[30:15];
    term_s    = $signed({{(ACC_W-16){1'b0}}, term});
  end

  // Shared multiplier
  assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  mcis_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = (!idx_ok || pre_delay) ? ST_IDLE : ST_KD;
      ST_KD:      state_nxt = ST_ALEN;
      ST_ALEN:    state_nxt = ST_ALEN_W;
      ST_ALEN_W:  state_nxt = ST_FLEN;
      ST_FLEN:    state_nxt = ST_FLEN_W;
      ST_FLEN_W:  state_nxt = ST_FS100;
      ST_FS100:   state_nxt = ST_FS100_W;
      ST_FS100_W: state_nxt = ST_M_FK;
      ST_M_FK:    state_nxt = ST_M_PH;
      ST_M_PH:    state_nxt = ST_M_PH_W;
      ST_M_PH_W:  if (div_done) state_nxt = ST_S1;
      ST_S1:      state_nxt = ST_S2;
      ST_S2:      state_nxt = ST_S3;
      ST_S3:      state_nxt = ST_S4;
      ST_S4:      state_nxt = ST_S5;
      ST_S5:      state_nxt = ST_W2;
      ST_W2:      state_nxt = ST_W3;
      ST_W3:      state_nxt = ST_W4;
      ST_W4:      state_nxt = ST_D_DIV;
      ST_D_DIV:   state_nxt = ST_D_W;
      ST_D_W: begin
        if (div_done) begin
          if (!decay_big) state_nxt = ST_D2;
          else            state_nxt = mode_last ? ST_A_CHK : ST_M_FK;
        end
      end
      ST_D2:      state_nxt = ST_D3;
      ST_D3:      state_nxt = ST_D4;
      ST_D4:      state_nxt = ST_D5;
      ST_D5:      state_nxt = mode_last ? ST_A_CHK : ST_M_FK;
      ST_A_CHK:   state_nxt = atk_on ? ST_A_W : ST_F_CHK;
      ST_A_W:     if (div_done) state_nxt = ST_A2;
      ST_A2:      state_nxt = ST_A3;
      ST_A3:      state_nxt = ST_F_CHK;
      ST_F_CHK:   state_nxt = fade_on ? ST_F_W : ST_OUT;
      ST_F_W:     if (div_done) state_nxt = ST_F2;
      ST_F2:      state_nxt = ST_OUT;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath steps and result
  always_comb begin
    n_nxt      = n_r;
    k_nxt      = k_r;
    kd_nxt     = kd_r;
    alen_nxt   = alen_r;
    flen_nxt   = flen_r;
    m_nxt      = m_r;
    ph_nxt     = ph_r;
    z_nxt      = z_r;
    z2_nxt     = z2_r;
    s_nxt      = s_r;
    neg_nxt    = neg_r;
    tmag_nxt   = tmag_r;
    u_nxt      = u_r;
    i_nxt      = i_r;
    acc_nxt    = acc_r;
    strobe_nxt = 1'b0;
    sample_nxt = sample_r;
    ivalid_nxt = ivalid_r;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    unique case (state_r)
      ST_IDLE: if (start) n_nxt = in_sample_index;
      ST_CHECK: begin
        if (!idx_ok) begin
          strobe_nxt = 1'b1;
          sample_nxt = '0;
          ivalid_nxt = 1'b0;
        end else if (pre_delay) begin
          strobe_nxt = 1'b1;
          sample_nxt = '0;
          ivalid_nxt = 1'b1;
        end else begin
          k_nxt   = n_r - 14'(sample_delay_r);
          acc_nxt = '0;
          m_nxt   = '0;
        end
      end
      ST_KD: begin
        mul_a = DECAY_K;
        mul_b = MUL_BW'(k_r);
      end
      ST_ALEN: begin
        // attack length: fs / 1000 by reciprocal
        kd_nxt = mul_r[50:0];
        mul_a  = MUL_AW'(fs);
        mul_b  = RCP_1000;
      end
      ST_ALEN_W: alen_nxt = (mul_r[42:28] < len_d) ? mul_r[42:28] : len_d;
      ST_FLEN: begin
        // fade length: len / 10 by reciprocal
        mul_a = MUL_AW'(len);
        mul_b = RCP_10;
      end
      ST_FLEN_W: flen_nxt = mul_r[32:18];
      ST_FS100: begin
        // fade cap: fs / 100 by reciprocal
        mul_a = MUL_AW'(fs);
        mul_b = RCP_100;
      end
      ST_FS100_W: if (mul_r[38:24] < flen_r) flen_nxt = mul_r[38:24];
      ST_M_FK: begin
        mul_a = MUL_AW'(md.freq);
        mul_b = MUL_BW'(k_r);
      end
      ST_M_PH: begin
        div_req.start = 1'b1;
        div_req.steps = 6'd43;
        div_req.dvd   = {mul_r[26:0], 25'd0};
        div_req.dvs   = {16'd0, fs};
      end
      ST_M_PH_W: if (div_done) ph_nxt = quo[15:0] + phase_offset_r;
      ST_S1: begin
        // fold the phase into the first quadrant
        z_nxt   = ph_r[14] ? (15'd16384 - {1'b0, ph_r[13:0]}) : {1'b0, ph_r[13:0]};
        neg_nxt = ph_r[15];
        mul_a   = MUL_AW'(z_nxt);
        mul_b   = MUL_BW'(z_nxt);
      end
      ST_S2: begin
        z2_nxt = mul_r[28:14];
        mul_a  = MUL_AW'(mul_r[28:14]);
        mul_b  = 20'd2463;
      end
      ST_S3: begin
        mul_a = MUL_AW'(z2_r);
        mul_b = MUL_BW'(15'd21167 - {3'd0, mul_r[25:14]});
      end
      ST_S4: begin
        mul_a = MUL_AW'(z_r);
        mul_b = MUL_BW'(16'd51472 - {1'b0, mul_r[28:14]});
      end
      ST_S5: begin
        s_nxt = mul_r[29:14];
        mul_a = 37'd39322;
        mul_b = MUL_BW'(fav);
      end
      ST_W2: begin
        mul_a = MUL_AW'(md.amp);
        mul_b = MUL_BW'(17'd26214 + mul_r[32:16]);
      end
      ST_W3: begin
        mul_a = MUL_AW'(mul_r[31:16]);
        mul_b = MUL_BW'(s_r);
      end
      ST_W4: begin
        tmag_nxt = mul_r[30:15];
        mul_a    = MUL_AW'(fs);
        mul_b    = MUL_BW'(md.tau);
      end
      ST_D_DIV: begin
        div_req.start = 1'b1;
        div_req.steps = 6'd51;
        div_req.dvd   = {kd_r, 1'b0};
        div_req.dvs   = mul_r[33:0];
      end
      ST_D_W: begin
        if (div_done) begin
          if (decay_big) begin
            // decay underflows: drop the mode
            m_nxt = m_r + 4'd1;
          end else begin
            u_nxt = quo[15:0];
            i_nxt = quo[19:16];
            mul_a = MUL_AW'(quo[15:0]);
            mul_b = 20'd1543;
          end
        end
      end
      ST_D2: begin
        mul_a = MUL_AW'(u_r);
        mul_b = MUL_BW'(13'd7872 - {2'd0, mul_r[26:16]});
      end
      ST_D3: begin
        mul_a = MUL_AW'(u_r);
        mul_b = MUL_BW'(15'd22713 - {2'd0, mul_r[28:16]});
      end
      ST_D4: begin
        mul_a = MUL_AW'(tmag_r);
        mul_b = MUL_BW'((16'd32768 - {1'b0, mul_r[30:16]}) >> i_r);
      end
      ST_D5: begin
        acc_nxt = neg_r ? (acc_r - term_s) : (acc_r + term_s);
        m_nxt   = m_r + 4'd1;
      end
      ST_A_CHK: begin
        if (atk_on) begin
          div_req.start = 1'b1;
          div_req.steps = 6'd30;
          div_req.dvd   = {k_r, 38'd0};
          div_req.dvs   = {19'd0, alen_r};
        end
      end
      ST_A_W: begin
        mul_a = MUL_AW'(17'd65536 - quo[16:0]);
        mul_b = MUL_BW'(17'd65536 - quo[16:0]);
      end
      ST_A2: begin
        mul_a = 37'd42598;
        mul_b = MUL_BW'(mul_r[32:16]);
      end
      ST_A3: acc_nxt = acc_r + $signed({{(ACC_W-16){1'b0}}, mul_r[31:16]});
      ST_F_CHK: begin
        if (fade_on) begin
          div_req.start = 1'b1;
          div_req.steps = 6'd31;
          div_req.dvd   = {fi, 37'd0};
          div_req.dvs   = {19'd0, flen_r};
        end
      end
      ST_F_W: begin
        neg_nxt = acc_r[ACC_W-1];
        mul_a   = MUL_AW'(acc_mag);
        mul_b   = MUL_BW'(17'd65536 - quo[16:0]);
      end
      ST_F2: begin
        acc_nxt = neg_r ? -$signed(mul_r[37:16]) : $signed(mul_r[37:16]);
      end
      ST_OUT: begin
        strobe_nxt = 1'b1;
        ivalid_nxt = 1'b1;
        if (acc_r > 22'sd524287)       sample_nxt = 20'h7FFFF;
        else if (acc_r < -22'sd524288) sample_nxt = 20'h80000;
        else                           sample_nxt = acc_r[19:0];
      end
      default: ;
    endcase
  end

  // Hold control and configuration under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      strobe_r       <= 1'b0;
      cab_type_r     <= 2'd0;
      position_r     <= 16'd32768;
      phase_offset_r <= 16'd0;
      sample_delay_r <= 8'd0;
      length_r       <= 15'd3840;
      sample_rate_r  <= 18'd48000;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CAB_TYPE:     cab_type_r     <= cfg_data[1:0];
          CFG_POSITION:     position_r     <= cfg_data[15:0];
          CFG_PHASE_OFFSET: phase_offset_r <= cfg_data[15:0];
          CFG_SAMPLE_DELAY: sample_delay_r <= cfg_data[7:0];
          CFG_LENGTH:       length_r       <= cfg_data[14:0];
          CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Advance datapath
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    kd_r     <= kd_nxt;
    alen_r   <= alen_nxt;
    flen_r   <= flen_nxt;
    m_r      <= m_nxt;
    ph_r     <= ph_nxt;
    z_r      <= z_nxt;
    z2_r     <= z2_nxt;
    s_r      <= s_nxt;
    neg_r    <= neg_nxt;
    tmag_r   <= tmag_nxt;
    u_r      <= u_nxt;
    i_r      <= i_nxt;
    acc_r    <= acc_nxt;
    mul_r    <= mul_p;
    sample_r <= sample_nxt;
    ivalid_r <= ivalid_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_strobe       = strobe_r;
  assign out_sample_value = $signed(sample_r);
  assign out_index_valid  = ivalid_r;

endmodule
